// File: rtl/rc_receiver_frame_decoder_defines.svh
// ----------------------------------------------------------------------------
// Remote-control frame decoder assertion macros
// Shared macros for the concurrent checks on the decoder's ports.
// ----------------------------------------------------------------------------
`ifndef RC_RECEIVER_FRAME_DECODER_DEFINES_SVH
`define RC_RECEIVER_FRAME_DECODER_DEFINES_SVH

// Check that is switched off while reset is asserted.
`define RCFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds while reset is asserted.
`define RCFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/rcfd_pkg.sv
// ----------------------------------------------------------------------------
// Remote-control frame decoder package
// Types and constants shared by the byte collector and the frame decoder.
// ----------------------------------------------------------------------------
package rcfd_pkg;

  localparam int CNT_W     = 6;
  localparam int CH_W      = 11;
  localparam int SW_W      = 2;
  localparam int OUT_TDATA_W = 64;

  // Transaction kinds on the input channel (carried in tuser).
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_IDLE = 1'b1;

  // Switch position codes.
  localparam logic [SW_W-1:0] SW_KEEP = 2'd0;
  localparam logic [SW_W-1:0] SW_UP   = 2'd1;
  localparam logic [SW_W-1:0] SW_DOWN = 2'd2;
  localparam logic [SW_W-1:0] SW_MID  = 2'd3;

  // Control modes selected by switch 1.
  localparam logic [1:0] MODE_UP   = 2'd0;
  localparam logic [1:0] MODE_MID  = 2'd1;
  localparam logic [1:0] MODE_DOWN = 2'd2;

  localparam logic [CH_W-1:0] CH_CENTER = 11'd1024;

  // Frame byte positions that carry decoded fields.
  localparam int SW_BYTE    = 5;
  localparam int WHEEL_LO_B = 16;
  localparam int WHEEL_HI_B = 17;

  typedef struct packed {
    logic [7:0] b17;
    logic [7:0] b16;
    logic [7:0] b5;
    logic [7:0] b4;
    logic [7:0] b3;
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
  } frame_t;

  // First member sits in the highest bits, so right_horizontal lands at bit 0.
  typedef struct packed {
    logic                   middle_key;
    logic [1:0]             ctrl_mode;
    logic [SW_W-1:0]        right_switch;
    logic [SW_W-1:0]        left_switch;
    logic signed [CH_W-1:0] wheel_value;
    logic signed [CH_W-1:0] left_vertical;
    logic signed [CH_W-1:0] left_horizontal;
    logic signed [CH_W-1:0] right_vertical;
    logic signed [CH_W-1:0] right_horizontal;
  } result_t;

  localparam int RES_W = $bits(result_t);

endpackage

// File: rtl/rcfd_collect.sv
// ----------------------------------------------------------------------------
// Remote-control frame byte collector
// Counts received bytes, stores the first frame's worth and hands a complete
// frame to the decoder when a line-idle transaction closes it.
// ----------------------------------------------------------------------------
module rcfd_collect import rcfd_pkg::*; #(
  parameter int FRAME_BYTES = 18,
  parameter int MAX_BYTES   = 36
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       dec_ready,
  output logic       frame_valid,
  output frame_t     frame
);

  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_BYTES);
  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_BYTES);

  logic [7:0]       store_r [FRAME_BYTES];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             frame_valid_r, frame_valid_nxt;
  frame_t           frame_r, frame_nxt;
  logic             in_acc;
  logic             store_wr;

  assign in_acc   = in_tvalid && in_tready;
  assign store_wr = in_acc && (in_tuser == OP_DATA) && (count_r < FRAME_CNT);

  always_comb begin
    count_nxt       = count_r;
    frame_valid_nxt = frame_valid_r;
    if (dec_ready) begin
      frame_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      if (in_tuser == OP_DATA) begin
        if (count_r < MAX_CNT) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end else begin
        count_nxt = '0;
        if (count_r == FRAME_CNT) begin
          frame_valid_nxt = 1'b1;
        end
      end
    end
  end

  // Snapshot of the bytes that carry fields, taken as the frame closes.
  always_comb begin
    frame_nxt = frame_r;
    if (in_acc && (in_tuser == OP_IDLE) && (count_r == FRAME_CNT)) begin
      frame_nxt.b0  = store_r[0];
      frame_nxt.b1  = store_r[1];
      frame_nxt.b2  = store_r[2];
      frame_nxt.b3  = store_r[3];
      frame_nxt.b4  = store_r[4];
      frame_nxt.b5  = store_r[SW_BYTE];
      frame_nxt.b16 = store_r[WHEEL_LO_B];
      frame_nxt.b17 = store_r[WHEEL_HI_B];
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      store_r[count_r[IDX_W-1:0]] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    if (!rst_n) begin
      count_r       <= '0;
      frame_valid_r <= 1'b0;
    end else begin
      count_r       <= count_nxt;
      frame_valid_r <= frame_valid_nxt;
    end
  end

  assign frame_valid = frame_valid_r;
  assign frame       = frame_r;

endmodule

// File: rtl/rcfd_decode.sv
// ----------------------------------------------------------------------------
// Remote-control frame decoder stage
// Unpacks the channels and switches of a complete frame, updates the held
// control mode and middle key, and holds the result for the output channel.
// ----------------------------------------------------------------------------
module rcfd_decode import rcfd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   frame_valid,
  input  frame_t                 frame,
  output logic                   dec_ready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic            out_valid_r, out_valid_nxt;
  result_t         res_r, res_nxt;
  logic [1:0]      mode_r, mode_nxt;
  logic            key_r, key_nxt;
  logic [SW_W-1:0] sw1;
  logic [SW_W-1:0] sw2;
  logic            load;
  logic [CH_W-1:0] raw_rh, raw_rv, raw_lh, raw_lv, raw_wh;

  assign dec_ready = !out_valid_r || out_tready;
  assign load      = frame_valid && dec_ready;

  assign sw1 = frame.b5[7:6];
  assign sw2 = frame.b5[5:4];

  // Channels are packed back to back, least significant bit first.
  assign raw_rh = {frame.b1[2:0], frame.b0};
  assign raw_rv = {frame.b2[5:0], frame.b1[7:3]};
  assign raw_lh = {frame.b4[0], frame.b3, frame.b2[7:6]};
  assign raw_lv = {frame.b5[3:0], frame.b4[7:1]};
  assign raw_wh = {frame.b17[2:0], frame.b16};

  always_comb begin
    mode_nxt = mode_r;
    key_nxt  = key_r;
    unique case (sw1)
      SW_UP:   mode_nxt = MODE_UP;
      SW_DOWN: mode_nxt = MODE_DOWN;
      SW_MID: begin
        mode_nxt = MODE_MID;
        key_nxt  = (sw2 == SW_UP);
      end
      SW_KEEP: mode_nxt = mode_r;
    endcase
  end

  always_comb begin
    res_nxt                  = res_r;
    out_valid_nxt            = out_valid_r && !out_tready;
    if (load) begin
      out_valid_nxt            = 1'b1;
      res_nxt.right_horizontal = raw_rh - CH_CENTER;
      res_nxt.right_vertical   = raw_rv - CH_CENTER;
      res_nxt.left_horizontal  = raw_lh - CH_CENTER;
      res_nxt.left_vertical    = raw_lv - CH_CENTER;
      res_nxt.wheel_value      = raw_wh - CH_CENTER;
      res_nxt.left_switch      = sw1;
      res_nxt.right_switch     = sw2;
      res_nxt.ctrl_mode        = mode_nxt;
      res_nxt.middle_key       = key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mode_r      <= MODE_UP;
      key_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load) begin
        mode_r <= mode_nxt;
        key_r  <= key_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - RES_W)'(0), res_r};

endmodule

// File: rtl/rc_receiver_frame_decoder.sv
// A closed frame is held in the collector's frame register, then decoded into the result register.
// Throughput: one input transaction per cycle; input stalls only while a closed frame
// waits behind a stalled result.
// Data-byte transactions and badly sized frames produce no result.
// Reset (rst_n low, synchronous) clears the byte count, held mode and middle key.
// The frame store is not cleared; only bytes of the current frame are ever decoded.
// ----------------------------------------------------------------------------
// Remote-control receiver frame decoder
// Collects serial bytes into frames and decodes stick, wheel and switch fields.
// ----------------------------------------------------------------------------
module rc_receiver_frame_decoder import rcfd_pkg::*; #(
  parameter int FRAME_BYTES = 18,
  parameter int MAX_BYTES   = 36
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] opcode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [10:0] right_horizontal, [21:11] right_vertical, [32:22] left_horizontal,
  // [43:33] left_vertical, [54:44] wheel_value, [56:55] left_switch,
  // [58:57] right_switch, [60:59] ctrl_mode, [61] middle_key, [63:62] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic   frame_valid;
  frame_t frame;
  logic   dec_ready;

  assign in_tready = !frame_valid || dec_ready;

  rcfd_collect #(
    .FRAME_BYTES (FRAME_BYTES),
    .MAX_BYTES   (MAX_BYTES)
  ) u_collect (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .dec_ready   (dec_ready),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  rcfd_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame_valid),
    .frame       (frame),
    .dec_ready   (dec_ready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

// File: rtl/rcfd_checker.sv
// ----------------------------------------------------------------------------
// Remote-control frame decoder port checker
// Concurrent checks on the decoder's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "rc_receiver_frame_decoder_defines.svh"

module rcfd_checker import rcfd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  logic            out_stall;
  logic            idle_acc;
  logic [SW_W-1:0] res_sw1;
  logic [1:0]      res_mode;

  assign out_stall = out_tvalid && !out_tready;
  assign idle_acc  = in_tvalid && in_tready && (in_tuser == OP_IDLE);
  assign res_sw1   = out_tdata[56:55];
  assign res_mode  = out_tdata[60:59];

  // A stalled result transaction keeps its payload.
  `RCFD_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // A new result follows an accepted line-idle transaction.
  `RCFD_ASSERT(a_out_cause, $rose(out_tvalid) |-> $past(idle_acc, 2), "result without idle")

  // Switch 1 in the middle position forces mode one; in the up position mode zero.
  `RCFD_ASSERT(a_mode_mid, out_tvalid && res_sw1 == SW_MID |-> res_mode == MODE_MID, "bad mid mode")
  `RCFD_ASSERT(a_mode_up, out_tvalid && res_sw1 == SW_UP |-> res_mode == MODE_UP, "bad up mode")

  // No result is offered in the cycle after reset.
  `RCFD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind rc_receiver_frame_decoder rcfd_checker u_rcfd_checker (.*);
